### sv/stsc_pkg.sv
`default_nettype none
package stsc_pkg;

  localparam int KEYWORD_MAX = 6;
  localparam int FIFO_DEPTH = 8;
  localparam int RES_MAX = 4;

  typedef enum logic [2:0] {
    M_IDLE, M_IDENT, M_NUMI, M_NUMDOT, M_NUMF, M_STR, M_COMMENT, M_OPER
  } mode_t;

  localparam logic [5:0] K_LPAREN = 6'd0;
  localparam logic [5:0] K_RPAREN = 6'd1;
  localparam logic [5:0] K_LBRACE = 6'd2;
  localparam logic [5:0] K_RBRACE = 6'd3;
  localparam logic [5:0] K_SEMICOLON = 6'd4;
  localparam logic [5:0] K_COLON = 6'd5;
  localparam logic [5:0] K_COMMA = 6'd6;
  localparam logic [5:0] K_DOT = 6'd7;
  localparam logic [5:0] K_MINUS = 6'd8;
  localparam logic [5:0] K_PLUS = 6'd9;
  localparam logic [5:0] K_STAR = 6'd10;
  localparam logic [5:0] K_SLASH = 6'd11;
  localparam logic [5:0] K_BANG = 6'd12;
  localparam logic [5:0] K_EQUAL = 6'd14;
  localparam logic [5:0] K_LESS = 6'd16;
  localparam logic [5:0] K_GREATER = 6'd18;
  localparam logic [5:0] K_IDENT = 6'd20;
  localparam logic [5:0] K_STRING = 6'd21;
  localparam logic [5:0] K_NUMBER = 6'd22;
  localparam logic [5:0] K_AND = 6'd23;
  localparam logic [5:0] K_CLASS = 6'd24;
  localparam logic [5:0] K_ELSE = 6'd25;
  localparam logic [5:0] K_FALSE = 6'd26;
  localparam logic [5:0] K_FOR = 6'd27;
  localparam logic [5:0] K_FUN = 6'd28;
  localparam logic [5:0] K_IF = 6'd29;
  localparam logic [5:0] K_NIL = 6'd30;
  localparam logic [5:0] K_OR = 6'd31;
  localparam logic [5:0] K_PRINT = 6'd32;
  localparam logic [5:0] K_RETURN = 6'd33;
  localparam logic [5:0] K_SUPER = 6'd34;
  localparam logic [5:0] K_THIS = 6'd35;
  localparam logic [5:0] K_TRUE = 6'd36;
  localparam logic [5:0] K_VAR = 6'd37;
  localparam logic [5:0] K_WHILE = 6'd38;
  localparam logic [5:0] K_ERROR = 6'd39;
  localparam logic [5:0] K_EOF = 6'd40;

  localparam logic [1:0] E_NONE = 2'd0;
  localparam logic [1:0] E_UNTERMINATED = 2'd1;
  localparam logic [1:0] E_UNEXPECTED = 2'd2;

  typedef struct packed {
    logic [5:0] kind;
    logic [1:0] err;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] line;
    logic last;
  } tok_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic tok_t mk_tok(input logic [5:0] kind, input logic [1:0] err,
                                  input logic [15:0] s, input logic [15:0] e,
                                  input logic [15:0] line);
    tok_t t;
    t.kind = kind;
    t.err = err;
    t.start = s;
    t.len = (e >= s) ? e - s : 16'd0;
    t.line = line;
    t.last = 1'b0;
    return t;
  endfunction

  function automatic logic letter_byte(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic numeral_byte(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [5:0] oper_kind(input logic [7:0] p, input logic with_eq);
    logic [5:0] b;
    b = (p == "!") ? K_BANG : (p == "=") ? K_EQUAL : (p == "<") ? K_LESS : K_GREATER;
    return with_eq ? b + 6'd1 : b;
  endfunction

  // Bytes at or past the identifier's length are cleared, so a padded compare is exact
  // even when a saturated offset has let a later byte land past the end.
  function automatic logic [5:0] kw_kind(input logic [47:0] pre, input logic [15:0] len);
    logic [5:0] k;
    logic [47:0] word;
    k = K_IDENT;
    word = pre;
    for (int i = 0; i < KEYWORD_MAX; i++) begin
      if (16'(i) >= len) word[47 - 8 * i -: 8] = 8'h00;
    end
    if (len <= 16'(KEYWORD_MAX)) begin
      case (word)
        {"and", 24'h0}: k = K_AND;
        {"class", 8'h0}: k = K_CLASS;
        {"else", 16'h0}: k = K_ELSE;
        {"false", 8'h0}: k = K_FALSE;
        {"for", 24'h0}: k = K_FOR;
        {"fun", 24'h0}: k = K_FUN;
        {"if", 32'h0}: k = K_IF;
        {"nil", 24'h0}: k = K_NIL;
        {"or", 32'h0}: k = K_OR;
        {"print", 8'h0}: k = K_PRINT;
        "return": k = K_RETURN;
        {"super", 8'h0}: k = K_SUPER;
        {"this", 16'h0}: k = K_THIS;
        {"true", 16'h0}: k = K_TRUE;
        {"var", 24'h0}: k = K_VAR;
        {"while", 8'h0}: k = K_WHILE;
        default: k = K_IDENT;
      endcase
    end
    return k;
  endfunction

endpackage
`default_nettype wire

### sv/stsc_if.sv
`default_nettype none
interface stsc_in_if;
  logic valid;
  logic ready;
  logic [7:0] char_code;
  logic has_char;
  logic end_of_input;
  modport source(output valid, char_code, has_char, end_of_input, input ready);
  modport sink(input valid, char_code, has_char, end_of_input, output ready);
endinterface

interface stsc_out_if;
  logic valid;
  logic ready;
  logic [5:0] token_kind;
  logic [1:0] error_kind;
  logic [15:0] start_offset;
  logic [15:0] token_length;
  logic [15:0] line_number;
  logic last_token;
  modport source(output valid, token_kind, error_kind, start_offset, token_length,
                 line_number, last_token, input ready);
  modport sink(input valid, token_kind, error_kind, start_offset, token_length,
               line_number, last_token, output ready);
endinterface
`default_nettype wire

### sv/script_token_scanner_unit.sv
// Channel   Direction  Beat
// in_ch     sink       one source byte (or bare end marker) per beat
// out_ch    source     one token per beat
//
// One input beat is taken per cycle while the token queue has room for four tokens.
// Each byte is scanned in the cycle it is accepted; its tokens enter an eight-entry
// queue and leave one per cycle while out_ch is ready, so the rate is one byte per cycle when
// on average no more than one token per byte is produced, and the queue drain sets it otherwise.
// Reset clears the scanner to line one, offset zero, and empties the queue.
`default_nettype none
module script_token_scanner_unit (
  input wire clk,
  input wire rst,
  stsc_in_if.sink in_ch,
  stsc_out_if.source out_ch
);
  import stsc_pkg::*;

  mode_t mode, mode_next;
  logic [15:0] token_start, token_start_next;
  logic [15:0] position, position_next;
  logic [15:0] line_count, line_count_next;
  logic [7:0] prefix [KEYWORD_MAX];
  logic [7:0] prefix_next [KEYWORD_MAX];
  logic [7:0] pending, pending_next;

  tok_t res [RES_MAX];
  logic [2:0] res_count;

  tok_t fifo [FIFO_DEPTH];
  logic [2:0] head, tail;
  logic [3:0] count;

  logic in_fire, out_fire;

  assign in_ch.ready = (count <= 4'(FIFO_DEPTH - RES_MAX));
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  always_comb begin
    logic [7:0] c;
    logic [15:0] off, dot_off, idx;
    logic adv, fall;
    logic [15:0] fend;
    logic [2:0] n;
    c = in_ch.char_code;
    mode_next = mode;
    token_start_next = token_start;
    position_next = position;
    line_count_next = line_count;
    prefix_next = prefix;
    pending_next = pending;
    n = 3'd0;
    dot_off = 16'd0;
    adv = 1'b1;
    fall = 1'b0;
    off = 16'd0;
    idx = 16'd0;
    fend = 16'd0;
    for (int i = 0; i < RES_MAX; i++) res[i] = '0;

    if (in_ch.has_char) begin
      if (mode == M_NUMDOT) begin
        dot_off = position_next;
        position_next = sat_inc(position_next);
      end
      off = position_next;
      case (mode)
        M_IDENT: begin
          if (letter_byte(c) || numeral_byte(c)) begin
            idx = off - token_start;
            if (idx < 16'(KEYWORD_MAX)) prefix_next[idx[2:0]] = c;
          end else begin
            res[n[1:0]] = mk_tok(kw_kind({prefix[0], prefix[1], prefix[2], prefix[3],
                                          prefix[4], prefix[5]}, off - token_start),
                                 E_NONE, token_start, off, line_count_next);
            n = n + 3'd1;
            fall = 1'b1;
          end
        end
        M_NUMI: begin
          if (c == ".") begin
            pending_next = c;
            mode_next = M_NUMDOT;
            adv = 1'b0;
          end else if (!numeral_byte(c)) begin
            res[n[1:0]] = mk_tok(K_NUMBER, E_NONE, token_start, off, line_count_next);
            n = n + 3'd1;
            fall = 1'b1;
          end
        end
        M_NUMDOT: begin
          if (numeral_byte(c)) begin
            mode_next = M_NUMF;
          end else begin
            res[0] = mk_tok(K_NUMBER, E_NONE, token_start, dot_off, line_count_next);
            res[1] = mk_tok(K_DOT, E_NONE, dot_off, off, line_count_next);
            n = 3'd2;
            fall = 1'b1;
          end
        end
        M_NUMF: begin
          if (!numeral_byte(c)) begin
            res[n[1:0]] = mk_tok(K_NUMBER, E_NONE, token_start, off, line_count_next);
            n = n + 3'd1;
            fall = 1'b1;
          end
        end
        M_STR: begin
          if (c == "\"") begin
            res[n[1:0]] = mk_tok(K_STRING, E_NONE, token_start, sat_inc(off),
                                 line_count_next);
            n = n + 3'd1;
            mode_next = M_IDLE;
          end else if (c == 8'h0A) begin
            line_count_next = sat_inc(line_count_next);
          end
        end
        M_COMMENT: begin
          if (c == 8'h0A) fall = 1'b1;
        end
        M_OPER: begin
          if (pending == "/") begin
            if (c == "/") begin
              mode_next = M_COMMENT;
            end else begin
              res[n[1:0]] = mk_tok(K_SLASH, E_NONE, token_start, off, line_count_next);
              n = n + 3'd1;
              fall = 1'b1;
            end
          end else if (c == "=") begin
            res[n[1:0]] = mk_tok(oper_kind(pending, 1'b1), E_NONE, token_start,
                                 sat_inc(off), line_count_next);
            n = n + 3'd1;
            mode_next = M_IDLE;
          end else begin
            res[n[1:0]] = mk_tok(oper_kind(pending, 1'b0), E_NONE, token_start, off,
                                 line_count_next);
            n = n + 3'd1;
            fall = 1'b1;
          end
        end
        default: fall = 1'b1;
      endcase

      // Start of a new token on this byte, from idle or after the previous token or comment closed on it.
      if (fall) begin
        mode_next = M_IDLE;
        token_start_next = off;
        if (c == " " || c == 8'h0D || c == 8'h09) begin
          mode_next = M_IDLE;
        end else if (c == 8'h0A) begin
          line_count_next = sat_inc(line_count_next);
        end else if (letter_byte(c)) begin
          for (int i = 0; i < KEYWORD_MAX; i++) prefix_next[i] = 8'h00;
          prefix_next[0] = c;
          mode_next = M_IDENT;
        end else if (numeral_byte(c)) begin
          mode_next = M_NUMI;
        end else if (c == "(" || c == ")" || c == "{" || c == "}" || c == ";" ||
                     c == ":" || c == "," || c == "." || c == "-" || c == "+" ||
                     c == "*") begin
          res[n[1:0]] = mk_tok((c == "(") ? K_LPAREN : (c == ")") ? K_RPAREN :
                               (c == "{") ? K_LBRACE : (c == "}") ? K_RBRACE :
                               (c == ";") ? K_SEMICOLON : (c == ":") ? K_COLON :
                               (c == ",") ? K_COMMA : (c == ".") ? K_DOT :
                               (c == "-") ? K_MINUS : (c == "+") ? K_PLUS : K_STAR,
                               E_NONE, off, sat_inc(off), line_count_next);
          n = n + 3'd1;
        end else if (c == "!" || c == "=" || c == "<" || c == ">" || c == "/") begin
          pending_next = c;
          mode_next = M_OPER;
        end else if (c == "\"") begin
          mode_next = M_STR;
        end else begin
          res[n[1:0]] = mk_tok(K_ERROR, E_UNEXPECTED, off, sat_inc(off), line_count_next);
          n = n + 3'd1;
        end
      end
      if (adv) position_next = sat_inc(position_next);
    end

    if (in_ch.end_of_input) begin
      fend = position_next;
      case (mode_next)
        M_IDENT: begin
          res[n[1:0]] = mk_tok(kw_kind({prefix_next[0], prefix_next[1], prefix_next[2],
                                        prefix_next[3], prefix_next[4], prefix_next[5]},
                                       fend - token_start_next),
                               E_NONE, token_start_next, fend, line_count_next);
          n = n + 3'd1;
        end
        M_NUMI, M_NUMF: begin
          res[n[1:0]] = mk_tok(K_NUMBER, E_NONE, token_start_next, fend, line_count_next);
          n = n + 3'd1;
        end
        M_NUMDOT: begin
          res[n[1:0]] = mk_tok(K_NUMBER, E_NONE, token_start_next, fend, line_count_next);
          n = n + 3'd1;
          res[n[1:0]] = mk_tok(K_DOT, E_NONE, fend, sat_inc(fend), line_count_next);
          n = n + 3'd1;
          fend = sat_inc(fend);
        end
        M_STR: begin
          res[n[1:0]] = mk_tok(K_ERROR, E_UNTERMINATED, token_start_next, fend,
                               line_count_next);
          n = n + 3'd1;
        end
        M_OPER: begin
          res[n[1:0]] = mk_tok((pending_next == "/") ? K_SLASH :
                               oper_kind(pending_next, 1'b0),
                               E_NONE, token_start_next, fend, line_count_next);
          n = n + 3'd1;
        end
        default: ;
      endcase
      res[n[1:0]] = mk_tok(K_EOF, E_NONE, fend, fend, line_count_next);
      n = n + 3'd1;
      mode_next = M_IDLE;
      token_start_next = 16'd0;
      position_next = 16'd0;
      line_count_next = 16'd1;
      for (int i = 0; i < KEYWORD_MAX; i++) prefix_next[i] = 8'h00;
      pending_next = 8'h00;
    end

    if (n != 3'd0) res[n[1:0] - 2'd1].last = 1'b1;
    res_count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      token_start <= 16'd0;
      position <= 16'd0;
      line_count <= 16'd1;
      for (int i = 0; i < KEYWORD_MAX; i++) prefix[i] <= 8'h00;
      pending <= 8'h00;
      head <= '0;
      tail <= '0;
      count <= '0;
    end else begin
      if (in_fire) begin
        mode <= mode_next;
        token_start <= token_start_next;
        position <= position_next;
        line_count <= line_count_next;
        prefix <= prefix_next;
        pending <= pending_next;
        tail <= tail + res_count;
      end
      if (out_fire) head <= head + 3'd1;
      count <= count + (in_fire ? {1'b0, res_count} : 4'd0) - (out_fire ? 4'd1 : 4'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < RES_MAX; i++) begin
        if (3'(i) < res_count) fifo[tail + 3'(i)] <= res[i];
      end
    end
  end

  assign out_ch.valid = (count != 4'd0);
  assign out_ch.token_kind = fifo[head].kind;
  assign out_ch.error_kind = fifo[head].err;
  assign out_ch.start_offset = fifo[head].start;
  assign out_ch.token_length = fifo[head].len;
  assign out_ch.line_number = fifo[head].line;
  assign out_ch.last_token = fifo[head].last;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 4'(FIFO_DEPTH)) else $error("token queue overflow");
  a_no_room: assert property (@(posedge clk) disable iff (rst)
    (count > 4'(FIFO_DEPTH - RES_MAX)) |-> !in_ch.ready) else $error("ready without room");
  a_eoi_reset: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_ch.end_of_input) |=> (mode == M_IDLE && position == 16'd0))
    else $error("scanner not cleared after end of text");
  a_eoi_token: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_ch.end_of_input) |-> (res_count != 3'd0)) else $error("no EOF token");
`endif
endmodule
`default_nettype wire

### verif/script_token_scanner_unit_test.sv
`default_nettype none
module script_token_scanner_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import stsc_pkg::*;

  localparam logic [7:0] CH_NL = 8'h0A;

  typedef struct {
    logic [5:0] kind;
    logic [1:0] err;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] line;
    logic last;
  } token_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  stsc_in_if in_ch ();
  stsc_out_if out_ch ();

  script_token_scanner_unit dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  // Scanner state mirrored for prediction.
  mode_t lex_mode;
  logic [15:0] lex_start;
  logic [15:0] lex_pos;
  logic [15:0] lex_line;
  logic [7:0] lex_prefix [KEYWORD_MAX];
  logic [7:0] lex_held;

  token_t token_queue[$];
  token_t step_tokens[$];
  int mismatches = 0;
  int tokens_seen = 0;
  int bytes_sent = 0;
  longint cycle_count = 0;
  bit send_idle_on = 1'b1;
  bit drain_idle_on = 1'b1;
  longint hold_until = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("script_token_scanner_unit: mismatch");
      $finish;
    end
  end

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic bit alpha_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit digit_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  task automatic push_token(input logic [5:0] kind, input logic [1:0] err,
                            input logic [15:0] s, input logic [15:0] e);
    token_t t;
    t.kind = kind;
    t.err = err;
    t.start = s;
    t.len = (e >= s) ? e - s : 16'd0;
    t.line = lex_line;
    t.last = 1'b0;
    if (step_tokens.size() < 4) step_tokens.push_back(t);
  endtask

  function automatic logic [5:0] word_kind(input logic [15:0] e);
    logic [15:0] n;
    string w;
    n = e - lex_start;
    if (n > 16'(KEYWORD_MAX)) return K_IDENT;
    w = "";
    for (int i = 0; i < n; i++) w = {w, string'(lex_prefix[i])};
    case (w)
      "and": return K_AND;
      "class": return K_CLASS;
      "else": return K_ELSE;
      "false": return K_FALSE;
      "for": return K_FOR;
      "fun": return K_FUN;
      "if": return K_IF;
      "nil": return K_NIL;
      "or": return K_OR;
      "print": return K_PRINT;
      "return": return K_RETURN;
      "super": return K_SUPER;
      "this": return K_THIS;
      "true": return K_TRUE;
      "var": return K_VAR;
      "while": return K_WHILE;
      default: return K_IDENT;
    endcase
  endfunction

  function automatic logic [5:0] relop_kind(input logic [7:0] p, input bit eq);
    logic [5:0] b;
    b = (p == "!") ? K_BANG : (p == "=") ? K_EQUAL : (p == "<") ? K_LESS : K_GREATER;
    return eq ? b + 6'd1 : b;
  endfunction

  function automatic bit punct_kind(input logic [7:0] c, output logic [5:0] k);
    k = K_LPAREN;
    case (c)
      "(": k = K_LPAREN;
      ")": k = K_RPAREN;
      "{": k = K_LBRACE;
      "}": k = K_RBRACE;
      ";": k = K_SEMICOLON;
      ":": k = K_COLON;
      ",": k = K_COMMA;
      ".": k = K_DOT;
      "-": k = K_MINUS;
      "+": k = K_PLUS;
      "*": k = K_STAR;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  task automatic lexer_clear();
    lex_mode = M_IDLE;
    lex_start = '0;
    lex_pos = '0;
    lex_line = 16'd1;
    lex_held = '0;
    for (int i = 0; i < KEYWORD_MAX; i++) lex_prefix[i] = '0;
  endtask

  task automatic begin_token(input logic [7:0] c, input logic [15:0] off);
    logic [5:0] k;
    bit punct;
    lex_mode = M_IDLE;
    lex_start = off;
    punct = punct_kind(c, k);
    if (c == " " || c == 8'h0D || c == 8'h09) return;
    if (c == CH_NL) begin
      if (lex_line != 16'hFFFF) lex_line++;
    end else if (alpha_char(c)) begin
      for (int i = 0; i < KEYWORD_MAX; i++) lex_prefix[i] = '0;
      lex_prefix[0] = c;
      lex_mode = M_IDENT;
    end else if (digit_char(c)) begin
      lex_mode = M_NUMI;
    end else if (punct) begin
      push_token(k, E_NONE, off, bump(off));
    end else if (c == "!" || c == "=" || c == "<" || c == ">" || c == "/") begin
      lex_held = c;
      lex_mode = M_OPER;
    end else if (c == "\"") begin
      lex_mode = M_STR;
    end else begin
      push_token(K_ERROR, E_UNEXPECTED, off, bump(off));
    end
  endtask

  // Sets advance to 0 when the byte is a dot held after digits and position must not advance.
  task automatic scan_byte(input logic [7:0] c, input logic [15:0] off,
                           input logic [15:0] dot_off, output bit advance);
    logic [15:0] idx;
    advance = 1'b1;
    case (lex_mode)
      M_IDENT: begin
        if (alpha_char(c) || digit_char(c)) begin
          idx = off - lex_start;
          if (idx < 16'(KEYWORD_MAX)) lex_prefix[idx[2:0]] = c;
          return;
        end
        push_token(word_kind(off), E_NONE, lex_start, off);
      end
      M_NUMI: begin
        if (digit_char(c)) return;
        if (c == ".") begin
          lex_held = c;
          lex_mode = M_NUMDOT;
          advance = 1'b0;
          return;
        end
        push_token(K_NUMBER, E_NONE, lex_start, off);
      end
      M_NUMDOT: begin
        if (digit_char(c)) begin
          lex_mode = M_NUMF;
          return;
        end
        push_token(K_NUMBER, E_NONE, lex_start, dot_off);
        push_token(K_DOT, E_NONE, dot_off, off);
      end
      M_NUMF: begin
        if (digit_char(c)) return;
        push_token(K_NUMBER, E_NONE, lex_start, off);
      end
      M_STR: begin
        if (c == "\"") begin
          push_token(K_STRING, E_NONE, lex_start, bump(off));
          lex_mode = M_IDLE;
        end else if (c == CH_NL && lex_line != 16'hFFFF) begin
          lex_line++;
        end
        return;
      end
      M_COMMENT: begin
        if (c != CH_NL) return;
      end
      M_OPER: begin
        if (lex_held == "/") begin
          if (c == "/") begin
            lex_mode = M_COMMENT;
            return;
          end
          push_token(K_SLASH, E_NONE, lex_start, off);
        end else if (c == "=") begin
          push_token(relop_kind(lex_held, 1'b1), E_NONE, lex_start, bump(off));
          lex_mode = M_IDLE;
          return;
        end else begin
          push_token(relop_kind(lex_held, 1'b0), E_NONE, lex_start, off);
        end
      end
      default: ;
    endcase
    begin_token(c, off);
  endtask

  task automatic close_text();
    logic [15:0] e;
    e = lex_pos;
    case (lex_mode)
      M_IDENT: push_token(word_kind(e), E_NONE, lex_start, e);
      M_NUMI, M_NUMF: push_token(K_NUMBER, E_NONE, lex_start, e);
      M_NUMDOT: begin
        push_token(K_NUMBER, E_NONE, lex_start, lex_pos);
        push_token(K_DOT, E_NONE, lex_pos, bump(lex_pos));
        e = bump(lex_pos);
      end
      M_STR: push_token(K_ERROR, E_UNTERMINATED, lex_start, e);
      M_OPER: push_token((lex_held == "/") ? K_SLASH : relop_kind(lex_held, 1'b0),
                         E_NONE, lex_start, e);
      default: ;
    endcase
    push_token(K_EOF, E_NONE, e, e);
  endtask

  task automatic predict_tokens(input logic [7:0] c, input bit has, input bit eoi);
    logic [15:0] dot_off;
    bit adv;
    step_tokens.delete();
    dot_off = '0;
    if (has) begin
      if (lex_mode == M_NUMDOT) begin
        dot_off = lex_pos;
        lex_pos = bump(lex_pos);
      end
      scan_byte(c, lex_pos, dot_off, adv);
      if (adv) lex_pos = bump(lex_pos);
    end
    if (eoi) begin
      close_text();
      lexer_clear();
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) token_queue.push_back(step_tokens[i]);
  endtask

  // Sends one beat; the prediction is made at the edge where it is accepted.
  // Valid stays high after the beat so that the next one can follow at once.
  task automatic send_beat(input logic [7:0] c, input bit has, input bit eoi);
    while (send_idle_on && $urandom_range(99) < 27) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.char_code <= c;
    in_ch.has_char <= has;
    in_ch.end_of_input <= eoi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_tokens(c, has, eoi);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input bit finish_text);
    for (int i = 0; i < s.len(); i++)
      send_beat(s[i], 1'b1, finish_text && (i == s.len() - 1));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (token_queue.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (cycle_count < hold_until) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(drain_idle_on && $urandom_range(99) < 27);
    end
  end

  always @(posedge clk) begin
    token_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      tokens_seen++;
      if (token_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected token kind=%0d start=%0d", out_ch.token_kind,
                   out_ch.start_offset);
      end else begin
        want = token_queue.pop_front();
        if (out_ch.token_kind !== want.kind || out_ch.error_kind !== want.err ||
            out_ch.start_offset !== want.start || out_ch.token_length !== want.len ||
            out_ch.line_number !== want.line || out_ch.last_token !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("token %0d: expected k=%0d e=%0d s=%0d n=%0d l=%0d t=%0d, ",
                     tokens_seen, want.kind, want.err, want.start, want.len, want.line,
                     want.last, "got k=%0d e=%0d s=%0d n=%0d l=%0d t=%0d",
                     out_ch.token_kind, out_ch.error_kind, out_ch.start_offset,
                     out_ch.token_length, out_ch.line_number, out_ch.last_token);
        end
      end
    end
  end

  task automatic test_keywords_and_operators();
    send_text("and class else false for fun if nil or print return super ", 1'b0);
    send_text("this true var while whiles _x9 ", 1'b1);
    send_text("(){};:,.-+*/ != = == <<= >>=!", 1'b1);
    wait_drained();
  endtask

  task automatic test_literals_and_comments();
    send_text("12.5 7. 3.x \"a\nb\" // note\n9 @", 1'b1);
    send_text("\"open", 1'b1);
    send_text("4.", 1'b1);
    send_text("x//", 1'b1);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'h41, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    wait_drained();
  endtask

  function automatic string random_lexeme();
    string parts [12] = '{"var", "x1", "42", "3.14", "\"s\"", "==", "<=", "// c\n",
                          "\n", " ", "while", "print"};
    return parts[$urandom_range(11)];
  endfunction

  task automatic test_random_text(input int count);
    int sent;
    logic [7:0] c;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 75) begin
        string s;
        s = random_lexeme();
        send_text(s, 1'b0);
        sent += s.len();
      end else begin
        c = $urandom_range(255);
        send_beat(c, $urandom_range(9) != 0, $urandom_range(30) == 0);
        sent++;
      end
    end
    send_beat(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_back_pressure();
    hold_until = cycle_count + 60;
    send_text("a;b;c;d;e;f;g;h;i;j;1.;", 1'b1);
    wait_drained();
  endtask

  task automatic test_no_idle_stretch();
    send_idle_on = 1'b0;
    drain_idle_on = 1'b0;
    test_random_text(50);
    send_idle_on = 1'b1;
    drain_idle_on = 1'b1;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.char_code = '0;
    in_ch.has_char = 1'b0;
    in_ch.end_of_input = 1'b0;
    lexer_clear();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_keywords_and_operators();
    test_literals_and_comments();
    test_back_pressure();
    test_random_text(30);
    test_no_idle_stretch();
    test_random_text(15);
    wait_drained();
    repeat (20) @(posedge clk);
    $display("Scanned %0d beats into %0d tokens: keywords, operators, literals,",
             bytes_sent, tokens_seen);
    $display("comments, errors, random text and output stalls; %0d mismatches.",
             mismatches);
    if (mismatches == 0 && token_queue.size() == 0) begin
      $display("script_token_scanner_unit: match");
    end else begin
      $display("script_token_scanner_unit: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire
